/* rtl/core/adc_noise_statistics_defines.svh */
// Assertion macros shared by the converter noise statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ADC_NOISE_STATISTICS_DEFINES_SVH
`define ADC_NOISE_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ANS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ANS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ans_pkg.sv */
// Shared types, constants and width helpers for the converter noise statistics block.
// No dependencies.
`default_nettype none

package ans_pkg;

  localparam int unsigned CODE_BITS_DEF  = 24;
  localparam int unsigned MAX_WINDOW_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STATUS_W   = 8;
  localparam int unsigned IN_CODE_W  = 24;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WCOUNT_W   = 13;
  localparam int unsigned OUT_CODE_W = 24;
  localparam int unsigned FIX_W      = 32;
  localparam int unsigned QUO_W      = 64;
  localparam int unsigned ROOT_ITERS = 32;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned READY_BIT = 7;   // active-low converter ready
  localparam logic [3:0]  EXP_CH_RST = 4'd3;
  localparam logic [15:0] SETTLE_RST = 16'd256;
  localparam logic [12:0] WINDOW_RST = 13'd2048;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_CH = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_LOAD   = 4'd1,
    OP_UPDATE = 4'd2,
    OP_MULA   = 4'd3,
    OP_MULB   = 4'd4,
    OP_PREP   = 4'd5,
    OP_MDIV   = 4'd6,
    OP_SDIV   = 4'd7,
    OP_SQRT   = 4'd8,
    OP_FIN    = 4'd9,
    OP_EMIT   = 4'd10
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   first;   // first cycle of a multi-cycle phase: load operands
  } ans_cmd_t;

  typedef struct packed {
    logic fin_req;   // current item completes the window
  } ans_stat_t;

  // Result beat payload, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]            pad;
    logic [FIX_W-1:0]      std_code;
    logic [FIX_W-1:0]      mean_code;
    logic [OUT_CODE_W-1:0] peak_to_peak;
    logic [OUT_CODE_W-1:0] code_max;
    logic [OUT_CODE_W-1:0] code_min;
    logic [WCOUNT_W-1:0]   window_count;
    logic [CNT_W-1:0]      valid_total;
    logic [CNT_W-1:0]      error_total;
  } ans_result_t;

  function automatic int unsigned ans_win_w(int unsigned max_window);
    return $clog2(max_window + 1);
  endfunction

  function automatic int unsigned ans_sum_w(int unsigned code_bits, int unsigned max_window);
    return code_bits + ans_win_w(max_window);
  endfunction

  // n*Q - S*S shifted left by 16
  function automatic int unsigned ans_dvd_w(int unsigned code_bits, int unsigned max_window);
    return 2 * ans_sum_w(code_bits, max_window) + 16;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ans_ctrl.sv */
// Sequencer for the noise statistics block: handshakes and finalization phases.
// Depends on ans_pkg and adc_noise_statistics_defines.svh.
`default_nettype none
`include "adc_noise_statistics_defines.svh"

module ans_ctrl import ans_pkg::*; #(
  parameter int unsigned CODE_BITS  = CODE_BITS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ans_stat_t stat_i,
  output ans_cmd_t       cmd_o
);

  localparam int unsigned MULA_LEN = ans_win_w(MAX_WINDOW);
  localparam int unsigned MULB_LEN = ans_sum_w(CODE_BITS, MAX_WINDOW);
  localparam int unsigned DIV_LEN  = ans_dvd_w(CODE_BITS, MAX_WINDOW);
  localparam int unsigned PH_W     = $clog2(DIV_LEN + 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_STEP = 10'b0000000010,
    ST_MULA = 10'b0000000100,
    ST_MULB = 10'b0000001000,
    ST_PREP = 10'b0000010000,
    ST_MDIV = 10'b0000100000,
    ST_SDIV = 10'b0001000000,
    ST_SQRT = 10'b0010000000,
    ST_FIN  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_e;

  state_e          state_q, state_d;
  logic [PH_W-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // run a phase of len steps after its load step
  function automatic logic ph_last(logic [PH_W-1:0] c, int unsigned len);
    return c == PH_W'(len);
  endfunction

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NOP;
    cmd_o.first = (cnt_q == '0);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.op = OP_UPDATE;
        cnt_d    = '0;
        state_d  = stat_i.fin_req ? ST_MULA : ST_EMIT;
      end
      ST_MULA: begin
        cmd_o.op = OP_MULA;
        if (ph_last(cnt_q, MULA_LEN)) begin
          cnt_d   = '0;
          state_d = ST_MULB;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MULB: begin
        cmd_o.op = OP_MULB;
        if (ph_last(cnt_q, MULB_LEN)) begin
          cnt_d   = '0;
          state_d = ST_PREP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        state_d  = ST_MDIV;
      end
      ST_MDIV: begin
        cmd_o.op = OP_MDIV;
        if (ph_last(cnt_q, DIV_LEN)) begin
          cnt_d   = '0;
          state_d = ST_SDIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SDIV: begin
        cmd_o.op = OP_SDIV;
        if (ph_last(cnt_q, DIV_LEN)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (ph_last(cnt_q, ROOT_ITERS)) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `ANS_ASSERT_NEXT(a_accept_step, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_STEP, "accepted beat not processed")
  `ANS_ASSERT_NEXT(a_fin_emit, clk_i, rst_ni, state_q == ST_FIN, state_q == ST_EMIT, "final statistics not emitted")
  `ANS_ASSERT_NEXT(a_phase_clr, clk_i, rst_ni, state_q == ST_STEP, cnt_q == '0, "phase counter not cleared")
  `ANS_ASSERT_SAME(a_idle_cnt, clk_i, rst_ni, state_q == ST_IDLE, cnt_q == '0, "phase counter busy in idle")

endmodule

`default_nettype wire

/* rtl/core/ans_datapath.sv */
// Datapath: config registers, window accumulators, shift-add multiplier,
// restoring divider and bitwise square root. Depends on ans_pkg.
`default_nettype none

module ans_datapath import ans_pkg::*; #(
  parameter int unsigned CODE_BITS  = CODE_BITS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  rd_err_i,
  input  wire logic [STATUS_W-1:0]   status_i,
  input  wire logic [IN_CODE_W-1:0]  code_i,
  input  wire ans_cmd_t              cmd_i,
  output ans_stat_t                  stat_o,
  output ans_result_t                res_o,
  output logic                       done_o
);

  localparam int unsigned NW     = ans_win_w(MAX_WINDOW);
  localparam int unsigned SUM_W  = ans_sum_w(CODE_BITS, MAX_WINDOW);
  localparam int unsigned SQ_W   = 2 * CODE_BITS + NW;
  localparam int unsigned PROD_W = 2 * SUM_W;
  localparam int unsigned DVD_W  = ans_dvd_w(CODE_BITS, MAX_WINDOW);
  localparam int unsigned DVSR_W = 2 * NW;

  // configuration
  logic [3:0]  exp_ch_q;
  logic [12:0] window_q;

  // captured beat
  logic                 rd_err_q;
  logic [STATUS_W-1:0]  status_q;
  logic [CODE_BITS-1:0] code_q;

  // window state
  logic                 fin_q;
  logic [CNT_W-1:0]     err_cnt_q, val_cnt_q;
  logic [15:0]          skip_q;
  logic [NW-1:0]        acc_cnt_q;
  logic [CODE_BITS-1:0] min_q, max_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SQ_W-1:0]      sq_q;
  logic [FIX_W-1:0]     mean_q, std_q;

  // finalization units
  logic [PROD_W-1:0] mul_acc_q, mul_cand_q, a_q;
  logic [SUM_W-1:0]  mul_plier_q;
  logic [DVD_W-1:0]  dv_q, div_dvd_q;
  logic [DVSR_W-1:0] dvsr_q, div_d_q, div_rem_q;
  logic [QUO_W-1:0]  div_quo_q;
  logic [63:0]       rt_v_q, rt_res_q, rt_bit_q;

  ans_result_t res_q;
  logic        done_q;

  // item classification
  logic               ready_n, is_err, is_rdy, take;
  logic [NW:0]        cnt_inc, target;
  logic [12:0]        tgt13;
  logic [2*CODE_BITS-1:0] code_sq;
  logic [DVSR_W:0]    trial;
  logic               div_ge;
  logic [63:0]        rt_trial;
  ans_result_t        res_d;

  assign ready_n = status_q[READY_BIT];
  assign is_err  = rd_err_q || (!ready_n && (status_q[3:0] != exp_ch_q));
  assign is_rdy  = !is_err && !ready_n;
  assign take    = is_rdy && (skip_q == '0);
  assign cnt_inc = {1'b0, acc_cnt_q} + 1'b1;
  assign code_sq = code_q * code_q;

  always_comb begin
    if (window_q < 13'd2) begin
      tgt13 = 13'd2;
    end else if (window_q > 13'(MAX_WINDOW)) begin
      tgt13 = 13'(MAX_WINDOW);
    end else begin
      tgt13 = window_q;
    end
  end
  assign target = (NW+1)'(tgt13);

  assign stat_o.fin_req = !fin_q && take && (cnt_inc >= target);

  // config and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q  <= EXP_CH_RST;
      window_q  <= WINDOW_RST;
      fin_q     <= 1'b0;
      err_cnt_q <= '0;
      val_cnt_q <= '0;
      skip_q    <= SETTLE_RST;
      acc_cnt_q <= '0;
      min_q     <= '1;
      max_q     <= '0;
      sum_q     <= '0;
      sq_q      <= '0;
      mean_q    <= '0;
      std_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_EXP_CH: exp_ch_q <= cfg_data_i[3:0];
          CFG_SETTLE: skip_q <= cfg_data_i;
          CFG_WINDOW: window_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_UPDATE && !fin_q) begin
        if (is_err) begin
          if (err_cnt_q != CNT_SAT) err_cnt_q <= err_cnt_q + 1'b1;
        end else if (!ready_n) begin
          if (val_cnt_q != CNT_SAT) val_cnt_q <= val_cnt_q + 1'b1;
          if (skip_q != '0) begin
            skip_q <= skip_q - 1'b1;
          end else begin
            if (code_q < min_q) min_q <= code_q;
            if (code_q > max_q) max_q <= code_q;
            sum_q     <= sum_q + SUM_W'(code_q);
            sq_q      <= sq_q + SQ_W'(code_sq);
            acc_cnt_q <= cnt_inc[NW-1:0];
          end
        end
      end
      if (cmd_i.op == OP_SDIV && cmd_i.first) mean_q <= div_quo_q[FIX_W-1:0];
      if (cmd_i.op == OP_FIN) begin
        std_q <= rt_res_q[FIX_W-1:0];
        fin_q <= 1'b1;
      end
    end
  end

  // captured beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      rd_err_q <= rd_err_i;
      status_q <= status_i;
      code_q   <= code_i[CODE_BITS-1:0];
    end
  end

  // shift-add multiplier: n*Q, then S*S
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MULA, OP_MULB: begin
        if (cmd_i.first) begin
          mul_acc_q <= '0;
          if (cmd_i.op == OP_MULA) begin
            mul_cand_q  <= PROD_W'(sq_q);
            mul_plier_q <= SUM_W'(acc_cnt_q);
          end else begin
            a_q         <= mul_acc_q;
            mul_cand_q  <= PROD_W'(sum_q);
            mul_plier_q <= sum_q;
          end
        end else begin
          if (mul_plier_q[0]) mul_acc_q <= mul_acc_q + mul_cand_q;
          mul_cand_q  <= {mul_cand_q[PROD_W-2:0], 1'b0};
          mul_plier_q <= {1'b0, mul_plier_q[SUM_W-1:1]};
        end
      end
      OP_PREP: begin
        dv_q   <= (a_q >= mul_acc_q) ? {a_q - mul_acc_q, 16'h0000} : '0;
        dvsr_q <= DVSR_W'(acc_cnt_q) * DVSR_W'(acc_cnt_q - NW'(1));
      end
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  assign trial  = {div_rem_q, div_dvd_q[DVD_W-1]};
  assign div_ge = trial >= {1'b0, div_d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MDIV || cmd_i.op == OP_SDIV) begin
      if (cmd_i.first) begin
        div_rem_q <= '0;
        div_quo_q <= '0;
        if (cmd_i.op == OP_MDIV) begin
          div_dvd_q <= DVD_W'({sum_q, {FRAC_BITS{1'b0}}});
          div_d_q   <= DVSR_W'(acc_cnt_q);
        end else begin
          div_dvd_q <= dv_q;
          div_d_q   <= dvsr_q;
        end
      end else begin
        div_rem_q <= div_ge ? DVSR_W'(trial - {1'b0, div_d_q}) : DVSR_W'(trial);
        div_dvd_q <= {div_dvd_q[DVD_W-2:0], 1'b0};
        div_quo_q <= {div_quo_q[QUO_W-2:0], div_ge};
      end
    end
  end

  // bitwise integer square root, two radicand bits per cycle
  assign rt_trial = rt_res_q + rt_bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQRT) begin
      if (cmd_i.first) begin
        rt_v_q   <= div_quo_q;
        rt_res_q <= '0;
        rt_bit_q <= 64'h4000_0000_0000_0000;
      end else begin
        if (rt_v_q >= rt_trial) begin
          rt_v_q   <= rt_v_q - rt_trial;
          rt_res_q <= {1'b0, rt_res_q[63:1]} + rt_bit_q;
        end else begin
          rt_res_q <= {1'b0, rt_res_q[63:1]};
        end
        rt_bit_q <= {2'b00, rt_bit_q[63:2]};
      end
    end
  end

  // result beat
  always_comb begin
    res_d.pad          = '0;
    res_d.error_total  = err_cnt_q;
    res_d.valid_total  = val_cnt_q;
    res_d.window_count = WCOUNT_W'(acc_cnt_q);
    res_d.code_min     = OUT_CODE_W'(min_q);
    res_d.code_max     = OUT_CODE_W'(max_q);
    res_d.peak_to_peak = (fin_q && max_q >= min_q) ? OUT_CODE_W'(max_q - min_q) : '0;
    res_d.mean_code    = mean_q;
    res_d.std_code     = std_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      res_q  <= res_d;
      done_q <= fin_q;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* rtl/core/adc_noise_statistics.sv */
// Converter noise statistics over a window: top level, sequencer plus datapath.
// Depends on ans_pkg, ans_ctrl and ans_datapath.
//
// Usage:
//  - Slave stream: one converter poll per beat. tdata carries the status byte
//    and the 24-bit code, tuser the read-error flag.
//  - Master stream: one result beat per accepted poll, carrying the counters,
//    min/max, peak-to-peak and the 24.8 mean and sample std; tuser is done.
//  - Config channel: index 0 expected channel, 1 settle skip (also reloads the
//    skip counter), 2 window length; always ready, write only while idle.
//  - Timing: a poll is taken in idle, updates state the next cycle and the
//    result is then loaded into the output register once that register is
//    free. The poll that fills the window runs finalization first: shift-add
//    n*Q and S*S, one prep step, two restoring divides and a bitwise square
//    root.
//  - A stalled receiver holds the result register; the next poll is still
//    accepted and processed, and waits only when its result is ready.
//  - Reset restores register defaults (channel 3, skip 256, window 2048) and
//    clears all statistics; after done every poll leaves state unchanged.
`default_nettype none

module adc_noise_statistics import ans_pkg::*; #(
  parameter int unsigned CODE_BITS  = CODE_BITS_DEF,
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // poll stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [31:0]           s_axis_tdata_i,   // [7:0] status_byte, [31:8] sample_code
  input  wire logic [0:0]            s_axis_tuser_i,   // [0] read_error
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [215:0]               m_axis_tdata_o,   // [31:0] error_total,
                                                       // [63:32] valid_total,
                                                       // [76:64] window_count,
                                                       // [100:77] code_min,
                                                       // [124:101] code_max,
                                                       // [148:125] peak_to_peak,
                                                       // [180:149] mean_code,
                                                       // [212:181] std_code, rest zero
  output logic [0:0]                 m_axis_tuser_o,   // [0] done_res
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ans_cmd_t    cmd;
  ans_stat_t   stat;
  ans_result_t res;
  logic        done;

  assign cfg_ready_o = 1'b1;

  ans_ctrl #(
    .CODE_BITS (CODE_BITS),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ans_datapath #(
    .CODE_BITS (CODE_BITS),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rd_err_i   (s_axis_tuser_i[0]),
    .status_i   (s_axis_tdata_i[7:0]),
    .code_i     (s_axis_tdata_i[31:8]),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res),
    .done_o     (done)
  );

  assign m_axis_tdata_o = res;
  assign m_axis_tuser_o = done;

endmodule

`default_nettype wire
